// ===== rtl/core/min_heap_extract_macros.svh =====
// Assertion macros used by the checker module of the heap block.
`ifndef MIN_HEAP_EXTRACT_MACROS_SVH
`define MIN_HEAP_EXTRACT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MHE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MHE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mhe_pkg.sv =====
// Types and constants shared by the heap extract block.
package mhe_pkg;

    localparam int MHE_HEAP_DEPTH = 256;
    localparam int MHE_KEY_W      = 32;
    localparam int MHE_PRIO_W     = 32;

    typedef struct packed {
        logic [MHE_KEY_W-1:0]         key;
        logic signed [MHE_PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [1:0] {
        ST_POPPED = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_LOADED = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROOT,
        S_CMP,
        S_LAST
    } t_state;

endpackage

// ===== rtl/core/min_heap_extract.sv =====
// Binary min-heap: loads append entries, pops return the root and sift down.
// A load, or a pop on an empty heap, is answered from the idle state and its
// result is registered at once. A pop on a non-empty heap reads the root and
// the last entry, registers the root priority as its result in S_ROOT, then
// sifts the last entry down from the root, comparing it with the smaller
// child in S_CMP at each level and writing it in S_CMP or S_LAST; when at most
// one entry is left, S_ROOT writes it to the root. The entry store reads both
// children of a level at once and writes one entry per cycle. A new
// transaction is taken once the sift has finished and the output register is
// free or being emptied.
module min_heap_extract
    import mhe_pkg::*;
#(
    parameter int HEAP_DEPTH = MHE_HEAP_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // [31:0] entry_key, [63:32] entry_priority
    input  logic [0:0]  i_s_tuser,  // [0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [31:0] popped_priority
    output logic [1:0]  o_m_tuser   // [1:0] status
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_pos, n_pos;
    t_entry             r_moved, n_moved;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic signed [31:0] r_out_prio, n_out_prio;

    logic               we;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    t_entry             rd_a;
    t_entry             rd_b;

    logic               out_free;
    logic               accept;
    logic [CW:0]        child;
    logic               has_right;
    logic               take_right;
    t_entry             chosen;
    logic [CW:0]        chosen_pos;
    logic [CW+1:0]      grand;
    logic [CW-1:0]      count_dec;
    logic [CW-1:0]      pos_dec;
    logic [CW:0]        root_left;

    mhe_ram #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_we        (we),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    assign count_dec  = r_count - 1'b1;
    assign pos_dec    = r_pos - 1'b1;
    assign child      = {r_pos, 1'b0};
    assign root_left  = (CW + 1)'(2);
    assign has_right  = child != {1'b0, r_count};
    assign take_right = has_right && (rd_b.prio < rd_a.prio);
    assign chosen     = take_right ? rd_b : rd_a;
    assign chosen_pos = child + (CW + 1)'(take_right);
    assign grand      = {chosen_pos, 1'b0};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_moved      = r_moved;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_prio   = r_out_prio;
        we           = 1'b0;
        wr_addr      = pos_dec[AW-1:0];
        wr_data      = r_moved;
        rd_addr_a    = '0;
        rd_addr_b    = count_dec[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out_prio  = '0;
                    if (t_mode'(i_s_tuser[0]) == MODE_LOAD) begin
                        if (r_count == CW'(HEAP_DEPTH)) begin
                            n_out_status = ST_FULL;
                        end else begin
                            n_out_status = ST_LOADED;
                            we           = 1'b1;
                            wr_addr      = r_count[AW-1:0];
                            wr_data.key  = i_s_tdata[31:0];
                            wr_data.prio = i_s_tdata[63:32];
                            n_count      = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_out_valid = r_out_valid && !i_m_tready;
                        n_count     = count_dec;
                        n_pos       = CW'(1);
                        n_state     = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_POPPED;
                n_out_prio   = rd_a.prio;
                n_moved      = rd_b;
                if (root_left <= {1'b0, r_count}) begin
                    rd_addr_a = AW'(root_left - 1'b1);
                    rd_addr_b = AW'(root_left);
                    n_state   = S_CMP;
                end else begin
                    we      = 1'b1;
                    wr_data = rd_b;
                    n_state = S_IDLE;
                end
            end
            S_CMP: begin
                we = 1'b1;
                if (chosen.prio < r_moved.prio) begin
                    wr_data = chosen;
                    n_pos   = chosen_pos[CW-1:0];
                    if (grand <= {2'b00, r_count}) begin
                        rd_addr_a = AW'(grand - 1'b1);
                        rd_addr_b = AW'(grand);
                    end else begin
                        n_state = S_LAST;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LAST: begin
                we      = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_moved      <= n_moved;
        r_out_status <= n_out_status;
        r_out_prio   <= n_out_prio;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_prio;
    assign o_m_tuser  = r_out_status;

endmodule

// ===== rtl/core/mhe_ram.sv =====
// Entry store with one write port and two registered read ports.
module mhe_ram
    import mhe_pkg::*;
#(
    parameter int DEPTH = MHE_HEAP_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output t_entry        o_rd_data_a,
    output t_entry        o_rd_data_b
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== rtl/core/mhe_checker.sv =====
// Port-level checker for the heap extract block, bound to the top level.
`include "min_heap_extract_macros.svh"

module mhe_checker
    import mhe_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [63:0] i_s_tdata,
    input logic [0:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    `MHE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "Stalled result changed")

    `MHE_ASSERT_NOW(a_zero_prio, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser != ST_POPPED), o_m_tdata == '0,
        "Priority not zero on a result that is not a pop")

    `MHE_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, o_s_tready,
        !o_m_tvalid || i_m_tready, "Input taken while the result slot is occupied")

    `MHE_ASSERT_NEXT(a_load_result, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready && (i_s_tuser[0] == MODE_LOAD),
        o_m_tvalid && ((o_m_tuser == ST_LOADED) || (o_m_tuser == ST_FULL)),
        "Load transaction did not give a load result in the next cycle")

endmodule

bind min_heap_extract mhe_checker u_mhe_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the min-heap extract block, with a predicting scoreboard.
module testbench;
    import mhe_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEMS_PER_PHASE = 15;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_status            status;
        logic signed [31:0] prio;
    } t_heap_outcome;

    class t_heap_scoreboard;
        logic [31:0]        keys[1:MHE_HEAP_DEPTH];
        logic signed [31:0] prios[1:MHE_HEAP_DEPTH];
        int                 entries_held;
        int                 deepest;
        int                 mismatches;
        int                 status_seen[4];
        t_heap_outcome      outcome_q[$];

        function new();
            entries_held = 0;
            deepest = 0;
            mismatches = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void note_item(t_mode mode, logic [31:0] key, logic signed [31:0] prio);
            t_heap_outcome      outcome;
            logic [31:0]        moved_key;
            logic signed [31:0] moved_prio;
            int                 pos;
            int                 child;
            outcome.prio = '0;
            if (mode == MODE_LOAD) begin
                if (entries_held >= MHE_HEAP_DEPTH) begin
                    outcome.status = ST_FULL;
                end else begin
                    entries_held++;
                    keys[entries_held] = key;
                    prios[entries_held] = prio;
                    outcome.status = ST_LOADED;
                    if (entries_held > deepest) deepest = entries_held;
                end
            end else if (entries_held == 0) begin
                outcome.status = ST_EMPTY;
            end else begin
                outcome.status = ST_POPPED;
                outcome.prio = prios[1];
                moved_key = keys[entries_held];
                moved_prio = prios[entries_held];
                entries_held--;
                pos = 1;
                while (2 * pos <= entries_held) begin
                    child = 2 * pos;
                    // The right child wins only when strictly smaller; ties keep the left.
                    if (child != entries_held && prios[child + 1] < prios[child]) child++;
                    if (prios[child] >= moved_prio) break;
                    keys[pos] = keys[child];
                    prios[pos] = prios[child];
                    pos = child;
                end
                keys[pos] = moved_key;
                prios[pos] = moved_prio;
            end
            outcome_q.push_back(outcome);
        endfunction

        function void check_result(logic [1:0] status, logic [31:0] prio);
            t_heap_outcome want;
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d priority %08h", status, prio);
                return;
            end
            want = outcome_q.pop_front();
            status_seen[want.status]++;
            if (status !== want.status || prio !== want.prio) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected status %s priority %08h, %s %0d priority %08h",
                             want.status.name(), want.prio, "got status", status, prio);
            end
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;  // [31:0] entry_key, [63:32] entry_priority
    logic [0:0]  i_s_tuser = '0;  // [0] mode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;       // [31:0] popped_priority
    logic [1:0]  o_m_tuser;       // [1:0] status

    int               sender_idle_pct = 0;
    int               receiver_stall_pct = 0;
    int               items_sent = 0;
    int               cycle_count = 0;
    t_heap_scoreboard sb = new();

    min_heap_extract u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_item(t_mode'(i_s_tuser[0]), i_s_tdata[31:0], i_s_tdata[63:32]);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tuser, o_m_tdata);
        end
    end

    task automatic send_item(t_mode mode, logic [31:0] key, logic [31:0] prio);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= mode;
        i_s_tdata <= {prio, key};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_pop();
        send_item(MODE_POP, $urandom, $urandom);
    endtask

    task automatic drain_heap();
        while (sb.entries_held > 0) send_pop();
    endtask

    // Appending values that never fall below the last one keeps the heap in order.
    function automatic longint rising_priority(longint floor_prio);
        longint next_prio;
        case ($urandom_range(3))
            0: next_prio = floor_prio;
            1: next_prio = floor_prio + $urandom_range(1, 255);
            2: next_prio = floor_prio + $urandom_range(1, 65535);
            default: next_prio = floor_prio + $urandom_range(0, 32'h00FF_FFFF);
        endcase
        if (next_prio > 64'sd2147483647) next_prio = 64'sd2147483647;
        return next_prio;
    endfunction

    initial begin : stimulus
        longint floor_prio;
        int     phase;
        int     phase_target;
        int     ops;
        int     i;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_pop();
        send_item(MODE_LOAD, 32'hFFFF_FFFF, 32'h8000_0000);
        send_pop();
        send_pop();
        send_item(MODE_LOAD, 32'h0000_0000, 32'h8000_0000);
        send_item(MODE_LOAD, 32'h5555_5555, 32'hFFFF_FFFF);
        send_item(MODE_LOAD, 32'hAAAA_AAAA, 32'h0000_0000);
        send_item(MODE_LOAD, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(MODE_LOAD, 32'h1234_5678, 32'h7FFF_FFFF);
        send_item(MODE_LOAD, 32'h0F0F_0F0F, 32'h0000_0000);
        send_item(MODE_LOAD, 32'hF0F0_F0F0, 32'h0000_0000);
        send_item(MODE_LOAD, 32'hDEAD_BEEF, 32'h8000_0001);
        repeat (9) send_pop();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
                default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
            endcase

            if (phase == 0) begin
                drain_heap();
                floor_prio = -64'sd1073741824 + $urandom_range(0, 65535);
                repeat (MHE_HEAP_DEPTH) begin
                    floor_prio = floor_prio + $urandom_range(0, 3);
                    send_item(MODE_LOAD, $urandom, floor_prio[31:0]);
                end
                send_item(MODE_LOAD, $urandom, $urandom);
                send_item(MODE_LOAD, 32'hFFFF_FFFF, 32'h8000_0000);
                drain_heap();
                send_pop();
            end

            phase_target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_target) begin
                if ($urandom_range(99) < 80) begin
                    drain_heap();
                    floor_prio = longint'($signed($urandom));
                    ops = ($urandom_range(9) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 30);
                    for (i = 0; i < ops; i++) begin
                        if (sb.entries_held == 0 ||
                            (sb.entries_held < MHE_HEAP_DEPTH && $urandom_range(99) < 60)) begin
                            floor_prio = rising_priority(floor_prio);
                            send_item(MODE_LOAD, $urandom, floor_prio[31:0]);
                        end else begin
                            send_pop();
                        end
                    end
                    drain_heap();
                    if ($urandom_range(99) < 30) send_pop();
                end else begin
                    repeat ($urandom_range(1, 8)) begin
                        if ($urandom_range(1) == 0)
                            send_item(MODE_LOAD, $urandom,
                                      $urandom_range(1) ? $urandom : $urandom_range(0, 3));
                        else
                            send_pop();
                    end
                end
            end
        end

        i_s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (sb.pending() > 0) begin
            sb.mismatches++;
            $display("%0d results never arrived", sb.pending());
        end
        $display("Sent %0d transactions across four idling phases; %s %0d of %0d entries.",
                 items_sent, "the heap reached", sb.deepest, MHE_HEAP_DEPTH);
        $display("Saw %0d pops, %0d pops on an empty heap, %0d loads and %0d refused loads;",
                 sb.status_seen[ST_POPPED], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_LOADED], sb.status_seen[ST_FULL]);
        $display("%0d mismatches.", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
